// ===== rtl/sgva_pkg.sv =====
// ---------------------------------------------------------------------------
// sgva_pkg
// Shared types and constants for the sparse GF(2) vector add/dot block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package sgva_pkg;

  // Capacity of one bank of the index list
  localparam int MAX_ENTRIES = 256;
  localparam int IDX_W       = 31;
  localparam int ADDR_W      = $clog2(MAX_ENTRIES);
  localparam int PTR_W       = ADDR_W + 1;   // holds 0..MAX_ENTRIES
  localparam int MEM_ADDR_W  = ADDR_W + 1;   // bank select + entry index
  localparam int SIZE_W      = 9;
  localparam int DIM_W       = 8;

  // Operation codes
  typedef enum logic [1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_APPEND = 2'd1,
    FUNC_ADD    = 2'd2,
    FUNC_DOT    = 2'd3
  } func_t;

  // Input transaction
  typedef struct packed {
    func_t            func;
    logic [IDX_W-1:0] element_index;
    logic             last_element;
  } cmd_t;

  // Result transaction
  typedef struct packed {
    logic              stream_done;
    logic              dot_parity;
    logic [SIZE_W-1:0] list_size;
    logic [DIM_W-1:0]  dimension;
    logic              overflow;
  } result_t;

endpackage

// ===== rtl/sgva_bank_mem.sv =====
// ---------------------------------------------------------------------------
// sgva_bank_mem
// Both index banks in one synchronous RAM: one write port and one read
// port, read data registered. Address MSB picks the bank.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sgva_bank_mem (
  input  logic                          clk,
  input  logic                          we,
  input  logic [sgva_pkg::MEM_ADDR_W-1:0] waddr,
  input  logic [sgva_pkg::IDX_W-1:0]      wdata,
  input  logic [sgva_pkg::MEM_ADDR_W-1:0] raddr,
  output logic [sgva_pkg::IDX_W-1:0]      rdata
);
  import sgva_pkg::*;

  logic [IDX_W-1:0] mem [0:(2*MAX_ENTRIES)-1];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/sparse_gf2_vector_add_dot.sv =====
// ---------------------------------------------------------------------------
// sparse_gf2_vector_add_dot
// Sparse GF(2) vector kept as a sorted index list, with merge-add and dot.
// ---------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; exactly one
// result follows, shown for one cycle with result_valid and not held, so the
// receiver must take it then. An add or dot element costs more the more
// stored entries smaller than the element the read pointer passes; the
// closing add element also copies the stored entries still left into the
// other bank. The cost is set by the single read port of the bank RAM: one
// stored entry is compared (and copied) per cycle. The list lives in two RAM
// banks; a merge streams from the active bank into the other and flips banks
// when the stream closes. No clearing pass.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sparse_gf2_vector_add_dot (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  sgva_pkg::cmd_t    cmd,
  output logic              busy,
  output logic              result_valid,
  output sgva_pkg::result_t result
);
  import sgva_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_TAIL,
    S_DONE
  } state_t;

  state_t state, state_next;

  // Control state
  logic             active, active_next;
  logic [PTR_W-1:0] count, count_next;
  logic [PTR_W-1:0] rp, rp_next;
  logic [PTR_W-1:0] wp, wp_next;
  logic             parity, parity_next;
  logic             ovf, ovf_next;
  logic             sdone, sdone_next;
  logic             spar, spar_next;
  logic             result_valid_next;

  // Payload
  cmd_t             op, op_next;
  result_t          result_next;

  // RAM port signals
  logic                  mem_we;
  logic [MEM_ADDR_W-1:0] mem_waddr;
  logic [IDX_W-1:0]      mem_wdata;
  logic [MEM_ADDR_W-1:0] mem_raddr;
  logic [IDX_W-1:0]      mem_rdata;

  // Merge output request
  logic             put_en;
  logic [IDX_W-1:0] put_val;

  logic             have;
  logic             hit;
  logic [PTR_W-1:0] rp_inc;
  logic [PTR_W-1:0] rp_new;
  logic [PTR_W-1:0] dim_full;

  sgva_bank_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign busy     = (state != S_IDLE);
  assign have     = (rp < count);
  assign hit      = have && (mem_rdata == op.element_index);
  assign rp_inc   = rp + PTR_W'(1);
  assign rp_new   = hit ? rp_inc : rp;
  assign dim_full = (count == '0) ? '0 : count - PTR_W'(1);

  // Sequencer next-state and RAM control
  always_comb begin
    state_next        = state;
    active_next       = active;
    count_next        = count;
    rp_next           = rp;
    wp_next           = wp;
    parity_next       = parity;
    ovf_next          = ovf;
    sdone_next        = sdone;
    spar_next         = spar;
    op_next           = op;
    result_valid_next = 1'b0;
    result_next       = result;
    mem_we            = 1'b0;
    mem_waddr         = '0;
    mem_wdata         = '0;
    mem_raddr         = {active, rp[ADDR_W-1:0]};
    put_en            = 1'b0;
    put_val           = '0;

    case (state)
      S_IDLE: begin
        if (start) begin
          op_next    = cmd;
          sdone_next = 1'b0;
          spar_next  = 1'b0;
          state_next = S_DONE;
          case (cmd.func)
            FUNC_CLEAR: begin
              count_next  = '0;
              ovf_next    = 1'b0;
              rp_next     = '0;
              wp_next     = '0;
              parity_next = 1'b0;
            end
            FUNC_APPEND: begin
              rp_next     = '0;
              wp_next     = '0;
              parity_next = 1'b0;
              if (count < PTR_W'(MAX_ENTRIES)) begin
                mem_we     = 1'b1;
                mem_waddr  = {active, count[ADDR_W-1:0]};
                mem_wdata  = cmd.element_index;
                count_next = count + PTR_W'(1);
              end else begin
                ovf_next = 1'b1;
              end
            end
            default: begin
              // add or dot: stored entry at rp is being read this cycle
              state_next = S_CMP;
            end
          endcase
        end
      end

      S_CMP: begin
        if (have && (mem_rdata < op.element_index)) begin
          // pass a smaller stored entry; an add copies it over
          put_en    = (op.func == FUNC_ADD);
          put_val   = mem_rdata;
          rp_next   = rp_inc;
          mem_raddr = {active, rp_inc[ADDR_W-1:0]};
        end else begin
          rp_next    = rp_new;
          mem_raddr  = {active, rp_new[ADDR_W-1:0]};
          sdone_next = op.last_element;
          state_next = S_DONE;
          if (op.func == FUNC_ADD) begin
            // equal indices cancel, otherwise the new index goes out
            put_en  = !hit;
            put_val = op.element_index;
            if (op.last_element) begin
              state_next = S_TAIL;
            end
          end else begin
            if (op.last_element) begin
              spar_next   = parity ^ hit;
              rp_next     = '0;
              wp_next     = '0;
              parity_next = 1'b0;
            end else begin
              parity_next = parity ^ hit;
            end
          end
        end
      end

      S_TAIL: begin
        if (have) begin
          // copy the rest of the stored list
          put_en    = 1'b1;
          put_val   = mem_rdata;
          rp_next   = rp_inc;
          mem_raddr = {active, rp_inc[ADDR_W-1:0]};
        end else begin
          active_next = ~active;
          count_next  = wp;
          rp_next     = '0;
          wp_next     = '0;
          parity_next = 1'b0;
          state_next  = S_DONE;
        end
      end

      S_DONE: begin
        result_valid_next       = 1'b1;
        result_next.stream_done = sdone;
        result_next.dot_parity  = spar;
        result_next.list_size   = SIZE_W'(count);
        result_next.dimension   = DIM_W'(dim_full);
        result_next.overflow    = ovf;
        state_next              = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    // merge output into the inactive bank, dropped when full
    if (put_en) begin
      if (wp < PTR_W'(MAX_ENTRIES)) begin
        mem_we    = 1'b1;
        mem_waddr = {~active, wp[ADDR_W-1:0]};
        mem_wdata = put_val;
        wp_next   = wp + PTR_W'(1);
      end else begin
        ovf_next = 1'b1;
      end
    end
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      active       <= 1'b0;
      count        <= '0;
      rp           <= '0;
      wp           <= '0;
      parity       <= 1'b0;
      ovf          <= 1'b0;
      sdone        <= 1'b0;
      spar         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      active       <= active_next;
      count        <= count_next;
      rp           <= rp_next;
      wp           <= wp_next;
      parity       <= parity_next;
      ovf          <= ovf_next;
      sdone        <= sdone_next;
      spar         <= spar_next;
      result_valid <= result_valid_next;
    end
    op     <= op_next;
    result <= result_next;
  end

endmodule

// ===== sim/sparse_gf2_vector_add_dot_tb.sv =====
// ---------------------------------------------------------------------------
// sparse_gf2_vector_add_dot_tb
// Self-checking testbench for the sparse GF(2) vector add/dot block.
// ---------------------------------------------------------------------------
// Commands go in one at a time over the start/busy handshake. A behavioral
// copy of the index list (two banks, read/write pointers, dot parity and the
// sticky overflow flag) predicts the result of every accepted transaction.
// The predictions queue up, and each strobed result is compared field by
// field with the oldest one. A short directed test, a capacity test and
// three random phases with different sender idle rates follow each other.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sparse_gf2_vector_add_dot_tb;
  import sgva_pkg::*;

  logic    clk;
  logic    rst;
  logic    start;
  cmd_t    cmd;
  logic    busy;
  logic    result_valid;
  result_t result;

  sparse_gf2_vector_add_dot dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .cmd          (cmd),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result)
  );

  // Shadow copy of the vector state
  logic [IDX_W-1:0] list_mem [2][MAX_ENTRIES];
  logic             list_bank;
  int               list_count;
  int               rd_ptr;
  int               wr_ptr;
  logic             dot_acc;
  logic             ovf_flag;

  // Predicted results, oldest first
  result_t pending_reports[$];

  int errors       = 0;
  int items_sent   = 0;
  int results_seen = 0;
  int streams_seen = 0;
  int odd_dots     = 0;
  int ovf_seen     = 0;
  int gap_pct      = 0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  initial begin
    #40_000_000;
    $display("%0t: run limit reached", $time);
    $display("TEST FAILED");
    $finish;
  end

  // -------------------------------------------------------------------------
  // Prediction
  // -------------------------------------------------------------------------

  function automatic void close_stream();
    rd_ptr  = 0;
    wr_ptr  = 0;
    dot_acc = 1'b0;
  endfunction

  // Write one merged index into the idle bank, or drop it when full
  function automatic void merge_out(logic [IDX_W-1:0] v);
    if (wr_ptr < MAX_ENTRIES) begin
      list_mem[list_bank ^ 1'b1][wr_ptr] = v;
      wr_ptr++;
    end else begin
      ovf_flag = 1'b1;
    end
  endfunction

  function automatic result_t gf2_vector_apply(cmd_t c);
    result_t          r;
    logic [IDX_W-1:0] x;
    r = '0;
    x = c.element_index;
    case (c.func)
      FUNC_CLEAR: begin
        list_count = 0;
        ovf_flag   = 1'b0;
        close_stream();
      end
      FUNC_APPEND: begin
        close_stream();
        if (list_count < MAX_ENTRIES) begin
          list_mem[list_bank][list_count] = x;
          list_count++;
        end else begin
          ovf_flag = 1'b1;
        end
      end
      FUNC_ADD: begin
        // copy smaller stored entries, then cancel or insert x
        while (rd_ptr < list_count && list_mem[list_bank][rd_ptr] < x) begin
          merge_out(list_mem[list_bank][rd_ptr]);
          rd_ptr++;
        end
        if (rd_ptr < list_count && list_mem[list_bank][rd_ptr] == x) rd_ptr++;
        else merge_out(x);
        if (c.last_element) begin
          while (rd_ptr < list_count) begin
            merge_out(list_mem[list_bank][rd_ptr]);
            rd_ptr++;
          end
          list_bank  = ~list_bank;
          list_count = wr_ptr;
          close_stream();
        end
        r.stream_done = c.last_element;
      end
      default: begin
        // dot: skip smaller entries, toggle parity on a match
        while (rd_ptr < list_count && list_mem[list_bank][rd_ptr] < x) rd_ptr++;
        if (rd_ptr < list_count && list_mem[list_bank][rd_ptr] == x) begin
          rd_ptr++;
          dot_acc = ~dot_acc;
        end
        if (c.last_element) begin
          r.dot_parity = dot_acc;
          close_stream();
        end
        r.stream_done = c.last_element;
      end
    endcase
    r.list_size = SIZE_W'((list_count > 511) ? 511 : list_count);
    r.dimension = DIM_W'((list_count == 0) ? 0 : ((list_count > 256) ? 255 : list_count - 1));
    r.overflow  = ovf_flag;
    return r;
  endfunction

  // Queue one predicted result behind the others
  function automatic void queue_report(result_t r);
    pending_reports = {pending_reports, r};
  endfunction

  // -------------------------------------------------------------------------
  // Result checking
  // -------------------------------------------------------------------------

  task automatic compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid) begin
      if (pending_reports.size() == 0) begin
        $display("%0t: result with no transaction pending, expected none, got %h",
                 $time, result);
        errors++;
      end else begin
        want = pending_reports.pop_front();
        compare_field("stream_done", want.stream_done, result.stream_done);
        compare_field("dot_parity", want.dot_parity, result.dot_parity);
        compare_field("list_size", want.list_size, result.list_size);
        compare_field("dimension", want.dimension, result.dimension);
        compare_field("overflow", want.overflow, result.overflow);
        results_seen++;
        if (want.stream_done) streams_seen++;
        if (want.dot_parity) odd_dots++;
        if (want.overflow) ovf_seen++;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Stimulus helpers
  // -------------------------------------------------------------------------

  // One transaction: optional idle gap, then hold start until accepted
  task automatic send_cmd(func_t f, logic [IDX_W-1:0] idx, logic is_last);
    cmd_t c;
    c.func          = f;
    c.element_index = idx;
    c.last_element  = is_last;
    if ($urandom_range(0, 99) < gap_pct) begin
      @(negedge clk);
      start <= 1'b0;
      repeat ($urandom_range(0, 3)) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    cmd   <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    queue_report(gf2_vector_apply(c));
    items_sent++;
  endtask

  // Drop start and hold off until every pending result is back
  task automatic wait_drain();
    @(negedge clk);
    start <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
  endtask

  // Index that often hits a stored entry, else small or full range
  function automatic logic [IDX_W-1:0] rand_idx();
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(0, 2))
      0: begin
        if (list_count > 0) return list_mem[list_bank][$urandom_range(0, list_count - 1)];
        return IDX_W'(r[7:0]);
      end
      1: return IDX_W'(r[7:0]);
      default: return r[IDX_W-1:0];
    endcase
  endfunction

  // Mostly keeps the stored list ascending
  function automatic logic [IDX_W-1:0] next_append();
    logic [IDX_W-1:0] top;
    if (list_count > 0 && $urandom_range(0, 4) != 0) begin
      top = list_mem[list_bank][list_count - 1];
      if (top < 31'h7FFF_FC00) return top + IDX_W'($urandom_range(1, 64));
    end
    return rand_idx();
  endfunction

  // Clear, then n ascending appends
  task automatic fill_list(int n);
    logic [IDX_W-1:0] v;
    send_cmd(FUNC_CLEAR, '0, 1'b0);
    v = IDX_W'($urandom_range(0, 1 << 30));
    repeat (n) begin
      send_cmd(FUNC_APPEND, v, 1'b0);
      v = v + IDX_W'($urandom_range(1, 1 << 20));
    end
  endtask

  // Stream of up to 8 elements. flaw: 0 sorted, 1 unsorted, 2 mixed add/dot,
  // 3 cut short by a clear or an append
  task automatic send_stream(func_t f, int flaw);
    logic [IDX_W-1:0] vals[$];
    logic [IDX_W-1:0] v;
    int               len;
    int               pos;
    int               i;
    len = $urandom_range((flaw == 3) ? 2 : 1, 8);
    for (i = 0; i < len; i++) begin
      v   = rand_idx();
      pos = vals.size();
      if (flaw != 1) while (pos > 0 && vals[pos-1] > v) pos--;
      vals.insert(pos, v);
    end
    for (i = 0; i < len; i++) begin
      if (flaw == 3 && i == len - 1) begin
        if ($urandom_range(0, 1)) send_cmd(FUNC_CLEAR, vals[i], 1'b1);
        else send_cmd(FUNC_APPEND, next_append(), 1'b0);
      end else if (flaw == 2) begin
        send_cmd(func_t'($urandom_range(FUNC_ADD, FUNC_DOT)), vals[i], i == len - 1);
      end else begin
        send_cmd(f, vals[i], i == len - 1);
      end
    end
  endtask

  // -------------------------------------------------------------------------
  // Tests
  // -------------------------------------------------------------------------

  task automatic test_directed();
    // clear ignores its index and last flag
    send_cmd(FUNC_CLEAR, 31'h7FFF_FFFF, 1'b1);
    send_cmd(FUNC_APPEND, 31'd0, 1'b0);
    send_cmd(FUNC_APPEND, 31'd5, 1'b0);
    send_cmd(FUNC_APPEND, 31'd100, 1'b1);
    send_cmd(FUNC_APPEND, 31'h7FFF_FFFF, 1'b0);
    // dot: two hits, then a single-element stream with one hit
    send_cmd(FUNC_DOT, 31'd5, 1'b0);
    send_cmd(FUNC_DOT, 31'd100, 1'b1);
    send_cmd(FUNC_DOT, 31'd0, 1'b1);
    // add: cancel 5 and the top index, insert 7
    send_cmd(FUNC_ADD, 31'd5, 1'b0);
    send_cmd(FUNC_ADD, 31'd7, 1'b0);
    send_cmd(FUNC_ADD, 31'h7FFF_FFFF, 1'b1);
    // append abandons an open add stream
    send_cmd(FUNC_ADD, 31'd3, 1'b0);
    send_cmd(FUNC_APPEND, 31'd200, 1'b0);
    // add inside a dot stream merges from the shared read pointer
    send_cmd(FUNC_DOT, 31'd7, 1'b0);
    send_cmd(FUNC_ADD, 31'd100, 1'b1);
    // unsorted dot and add streams
    send_cmd(FUNC_DOT, 31'd200, 1'b0);
    send_cmd(FUNC_DOT, 31'd0, 1'b1);
    send_cmd(FUNC_ADD, 31'd300, 1'b0);
    send_cmd(FUNC_ADD, 31'd250, 1'b1);
    // clear abandons an open add stream, then add into an empty list
    send_cmd(FUNC_ADD, 31'd0, 1'b0);
    send_cmd(FUNC_CLEAR, 31'd0, 1'b0);
    send_cmd(FUNC_ADD, 31'd9, 1'b1);
    // unsorted append, then a repeated dot element
    send_cmd(FUNC_APPEND, 31'd1, 1'b1);
    send_cmd(FUNC_DOT, 31'd9, 1'b0);
    send_cmd(FUNC_DOT, 31'd9, 1'b1);
  endtask

  task automatic test_capacity();
    logic [IDX_W-1:0] top;
    // append to a full list is dropped
    fill_list(MAX_ENTRIES);
    send_cmd(FUNC_APPEND, next_append(), 1'b0);
    send_stream(FUNC_DOT, 0);
    // cancel two entries; the flag stays set
    send_cmd(FUNC_ADD, list_mem[list_bank][3], 1'b0);
    send_cmd(FUNC_ADD, list_mem[list_bank][10], 1'b1);
    // merge that grows past capacity
    fill_list(MAX_ENTRIES - 2);
    top = list_mem[list_bank][list_count - 1];
    send_cmd(FUNC_ADD, top + 31'd1, 1'b0);
    send_cmd(FUNC_ADD, top + 31'd2, 1'b0);
    send_cmd(FUNC_ADD, top + 31'd3, 1'b1);
    send_stream(FUNC_DOT, 0);
    send_cmd(FUNC_APPEND, next_append(), 1'b0);
    send_cmd(FUNC_CLEAR, '0, 1'b0);
    wait_drain();
  endtask

  // Mostly well-formed streams with random content, some noise
  task automatic test_random(int pct, int n_items);
    int stop_at;
    int kind;
    gap_pct = pct;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      kind = $urandom_range(0, 99);
      if (list_count > 40 && $urandom_range(0, 1))
        send_cmd(FUNC_CLEAR, rand_idx(), 1'($urandom_range(0, 1)));
      else if (kind < 35) send_stream(FUNC_ADD, 0);
      else if (kind < 65) send_stream(FUNC_DOT, 0);
      else if (kind < 77) begin
        repeat ($urandom_range(1, 4))
          send_cmd(FUNC_APPEND, next_append(), 1'($urandom_range(0, 1)));
      end
      else if (kind < 81) send_cmd(FUNC_CLEAR, rand_idx(), 1'($urandom_range(0, 1)));
      else if (kind < 92)
        send_stream(func_t'($urandom_range(FUNC_ADD, FUNC_DOT)), $urandom_range(1, 3));
      else
        send_cmd(func_t'($urandom_range(0, 3)), IDX_W'($urandom()),
                 1'($urandom_range(0, 1)));
    end
    wait_drain();
  endtask

  task automatic finish_run();
    int n;
    @(negedge clk);
    start <= 1'b0;
    for (n = 0; n < 2000 && pending_reports.size() != 0; n++) @(posedge clk);
    repeat (20) @(posedge clk);
    if (pending_reports.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_reports.size());
      errors += pending_reports.size();
    end
    $display("Covered %0d transactions, %0d results checked: %0d streams closed,",
             items_sent, results_seen, streams_seen);
    $display("  %0d odd dot parities, %0d results with overflow set, full-list merges",
             odd_dots, ovf_seen);
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  endtask

  // -------------------------------------------------------------------------
  // Main sequence
  // -------------------------------------------------------------------------
  initial begin
    rst        = 1'b1;
    start      = 1'b0;
    cmd        = '0;
    list_bank  = 1'b0;
    list_count = 0;
    ovf_flag   = 1'b0;
    close_stream();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    gap_pct = 6;
    test_directed();
    test_capacity();
    test_random(6, 85);
    test_random(61, 85);
    test_random(0, 85);
    finish_run();
  end

endmodule
